// ===== design/hrcc_pkg.sv =====
// ============================================================================
// hrcc_pkg
// Shared types and constants for the HTTP response completeness check:
// result status codes, header flag positions and the header pattern texts.
// ============================================================================
package hrcc_pkg;

    // width of the count fields on the result item
    localparam int unsigned OUT_W = 32;

    // result status codes
    typedef enum logic [1:0] {
        ST_NEED_MORE      = 2'd0,
        ST_COMPLETE       = 2'd1,
        ST_COMPLETE_CLOSE = 2'd2,
        ST_ERROR          = 2'd3
    } t_status;

    // header flag bit positions
    localparam int unsigned FLAG_CLOSE = 0;
    localparam int unsigned FLAG_LEN   = 1;
    localparam int unsigned FLAG_CHUNK = 2;
    localparam int unsigned FLAG_W     = 3;

    // header patterns, stored lower case; matching folds the input byte
    localparam int unsigned NPAT    = 5;
    localparam int unsigned PAT_MAX = 26;

    localparam int unsigned PAT_CLOSE_A = 0;
    localparam int unsigned PAT_CLOSE_B = 1;
    localparam int unsigned PAT_LENGTH  = 2;
    localparam int unsigned PAT_CHUNK_A = 3;
    localparam int unsigned PAT_CHUNK_B = 4;

    typedef logic [PAT_MAX*8-1:0] t_pat_text;

    // first character sits in the highest used byte of each entry
    localparam t_pat_text PAT_TEXT [NPAT] = '{
        "connection: close",
        "connection:close",
        "content-length:",
        "transfer-encoding: chunked",
        "transfer-encoding:chunked"
    };

    localparam int unsigned PAT_LEN [NPAT] = '{17, 16, 15, 26, 25};

    localparam int unsigned PAT_FLAG [NPAT] = '{
        FLAG_CLOSE, FLAG_CLOSE, FLAG_LEN, FLAG_CHUNK, FLAG_CHUNK
    };

endpackage

// ===== design/hrcc_pat_match.sv =====
// ============================================================================
// hrcc_pat_match
// Case-insensitive substring matcher for one header pattern. Keeps one bit
// per matched prefix length (shift-and form) and flags a complete match on
// the byte that finishes the pattern.
// ============================================================================
module hrcc_pat_match #(
    parameter int unsigned PAT_IDX = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_clear,
    input  logic       i_step,
    input  logic [7:0] i_char,
    output logic       o_hit
);
    import hrcc_pkg::*;

    localparam int unsigned PLEN = PAT_LEN[PAT_IDX];
    localparam t_pat_text   TXT  = PAT_TEXT[PAT_IDX];

    logic [PLEN-1:1] r_prog;
    logic [PLEN-1:1] n_prog;
    logic [PLEN-1:0] eq;

    // per-position compare against the folded byte
    always_comb begin
        for (int k = 0; k < PLEN; k++) begin
            eq[k] = (i_char == TXT[(PLEN-1-k)*8 +: 8]);
        end
    end

    // advance every live prefix by one character
    always_comb begin
        n_prog = r_prog;
        if (i_clear) begin
            n_prog = '0;
        end else if (i_step) begin
            n_prog[1] = eq[0];
            for (int k = 1; k < PLEN-1; k++) begin
                n_prog[k+1] = r_prog[k] & eq[k];
            end
        end
    end

    assign o_hit = i_step & ~i_clear & r_prog[PLEN-1] & eq[PLEN-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog <= '0;
        end else begin
            r_prog <= n_prog;
        end
    end

endmodule

// ===== design/hrcc_num_parse.sv =====
// ============================================================================
// hrcc_num_parse
// Content length value parser. Skips leading white space, takes an optional
// sign, then accumulates decimal digits with saturation at the field maximum.
// Gives the value and the negative flag as they stand after the current byte.
// ============================================================================
module hrcc_num_parse #(
    parameter int unsigned LENGTH_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_clear,
    input  logic                   i_step,
    input  logic                   i_start,
    input  logic [7:0]             i_char,
    output logic [LENGTH_BITS-1:0] o_value_next,
    output logic                   o_error_next
);
    import hrcc_pkg::*;

    typedef enum logic [2:0] {
        NUM_IDLE,
        NUM_WS,
        NUM_SIGN,
        NUM_DIGITS,
        NUM_DONE
    } t_num_phase;

    t_num_phase             r_phase;
    t_num_phase             n_phase;
    t_num_phase             cur_phase;
    logic [LENGTH_BITS-1:0] r_value;
    logic [LENGTH_BITS-1:0] n_value;
    logic [LENGTH_BITS-1:0] cur_value;
    logic                   r_error;
    logic                   n_error;
    logic                   cur_error;

    logic                   is_ws;
    logic                   is_digit;
    logic                   is_sign;
    logic [LENGTH_BITS+3:0] acc;
    logic [LENGTH_BITS-1:0] acc_sat;

    // a fresh response starts from the cleared state
    assign cur_phase = i_clear ? NUM_IDLE : r_phase;
    assign cur_value = i_clear ? '0 : r_value;
    assign cur_error = i_clear ? 1'b0 : r_error;

    // character classes
    assign is_ws    = i_char inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    assign is_digit = i_char inside {[8'h30:8'h39]};
    assign is_sign  = (i_char == 8'h2B) || (i_char == 8'h2D);

    // value * 10 + digit, saturating
    assign acc = ({4'b0, cur_value} << 3) + ({4'b0, cur_value} << 1)
               + {{LENGTH_BITS{1'b0}}, i_char[3:0]};
    assign acc_sat = (|acc[LENGTH_BITS+3:LENGTH_BITS]) ? '1 : acc[LENGTH_BITS-1:0];

    // per-byte parse step
    always_comb begin
        n_phase = cur_phase;
        n_value = cur_value;
        n_error = cur_error;
        if (i_step) begin
            case (cur_phase)
                NUM_WS: begin
                    if (is_ws) begin
                        n_phase = NUM_WS;
                    end else if (is_sign) begin
                        n_error = (i_char == 8'h2D);
                        n_phase = NUM_SIGN;
                    end else if (is_digit) begin
                        n_value = acc_sat;
                        n_phase = NUM_DIGITS;
                    end else begin
                        n_phase = NUM_DONE;
                    end
                end
                NUM_SIGN, NUM_DIGITS: begin
                    if (is_digit) begin
                        n_value = acc_sat;
                        n_phase = NUM_DIGITS;
                    end else begin
                        n_phase = NUM_DONE;
                    end
                end
                default: begin
                    n_phase = cur_phase;
                end
            endcase
            if (i_start) begin
                n_phase = NUM_WS;
            end
        end
    end

    assign o_value_next = n_value;
    assign o_error_next = n_error;

    // state and value registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= NUM_IDLE;
            r_value <= '0;
            r_error <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_value <= n_value;
            r_error <= n_error;
        end
    end

endmodule

// ===== design/http_response_completeness_check.sv =====
// ============================================================================
// http_response_completeness_check
// Byte-serial HTTP response framing check: tracks the status line, header and
// body, matches close/length/chunked header patterns, parses the content
// length and reports after every byte whether the response is complete.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   input   | in        | i_valid / o_stall  | i_rx_byte, i_new_response
//   result  | out       | o_valid / i_stall  | o_status, o_header_seen,
//           |           |                    | o_close_seen, o_length_seen,
//           |           |                    | o_chunked_seen, o_content_length,
//           |           |                    | o_body_bytes
//
// One byte per cycle sustained while i_stall is low; an accepted byte enters
// the input register; its result loads into the result register once free.
// The parser state advances when a byte moves from the input register into
// the result register; the whole update is one combinational pass.
// i_stall holds the result register; the input register still fills, and
// o_stall rises only when both stages are full.
// Reset clears all parser state, both stage valid bits and the outputs.
// ============================================================================
module http_response_completeness_check #(
    parameter int unsigned LENGTH_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [7:0]                   i_rx_byte,
    input  logic                         i_new_response,
    output logic                         o_valid,
    input  logic                         i_stall,
    output hrcc_pkg::t_status            o_status,
    output logic                         o_header_seen,
    output logic                         o_close_seen,
    output logic                         o_length_seen,
    output logic                         o_chunked_seen,
    output logic [hrcc_pkg::OUT_W-1:0]   o_content_length,
    output logic [hrcc_pkg::OUT_W-1:0]   o_body_bytes
);
    import hrcc_pkg::*;

    typedef enum logic [1:0] {
        PH_STATUS,
        PH_HEADER,
        PH_BODY
    } t_phase;

    localparam logic [1:0] CRLF_NONE   = 2'd0;
    localparam logic [1:0] CRLF_CR     = 2'd1;
    localparam logic [1:0] CRLF_CRLF   = 2'd2;
    localparam logic [1:0] CRLF_CRLFCR = 2'd3;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // input register
    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_new;

    // parser state
    t_phase                 r_phase;
    t_phase                 n_phase;
    t_phase                 cur_phase;
    logic [1:0]             r_crlf;
    logic [1:0]             n_crlf;
    logic [1:0]             cur_crlf;
    logic [FLAG_W-1:0]      r_flags;
    logic [FLAG_W-1:0]      n_flags;
    logic [FLAG_W-1:0]      cur_flags;
    logic [LENGTH_BITS-1:0] r_body;
    logic [LENGTH_BITS-1:0] n_body;
    logic [LENGTH_BITS-1:0] cur_body;

    // result register
    logic                   r_out_valid;
    t_status                r_out_status;
    logic                   r_out_header;
    logic [FLAG_W-1:0]      r_out_flags;
    logic [OUT_W-1:0]       r_out_length;
    logic [OUT_W-1:0]       r_out_body;

    logic                   out_free;
    logic                   move;
    logic                   clear;
    logic                   step;
    logic [7:0]             fold_char;
    logic [NPAT-1:0]        hit;
    logic                   len_start;
    logic                   first_crlf;
    logic                   end_header;
    logic [LENGTH_BITS-1:0] len_next;
    logic                   len_err_next;
    t_status                n_status;
    logic [OUT_W+LENGTH_BITS-1:0] len_ext;
    logic [OUT_W+LENGTH_BITS-1:0] body_ext;

    // handshake between the two stages
    assign out_free = ~r_out_valid | ~i_stall;
    assign move     = r_in_valid & out_free;
    assign o_stall  = r_in_valid & ~out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_rx_byte;
            r_in_new  <= i_new_response;
        end
    end

    // state seen by this byte, after an optional restart
    assign clear     = move & r_in_new;
    assign cur_phase = clear ? PH_STATUS : r_phase;
    assign cur_crlf  = clear ? CRLF_NONE : r_crlf;
    assign cur_flags = clear ? '0 : r_flags;
    assign cur_body  = clear ? '0 : r_body;
    assign step      = move & (cur_phase == PH_HEADER);

    // fold upper case letters for the matchers
    assign fold_char = (r_in_byte inside {[8'h41:8'h5A]}) ? (r_in_byte | 8'h20) : r_in_byte;

    // header pattern matchers
    for (genvar g = 0; g < NPAT; g++) begin : g_pat
        hrcc_pat_match #(
            .PAT_IDX (g)
        ) u_pat (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (clear),
            .i_step  (step),
            .i_char  (fold_char),
            .o_hit   (hit[g])
        );
    end

    // only the first length pattern starts the number parser
    assign len_start = hit[PAT_LENGTH] & ~cur_flags[FLAG_LEN];

    hrcc_num_parse #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_num (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (clear),
        .i_step       (step),
        .i_start      (len_start),
        .i_char       (r_in_byte),
        .o_value_next (len_next),
        .o_error_next (len_err_next)
    );

    // crlf tracking, body count, header flags and phase update
    always_comb begin
        n_phase    = cur_phase;
        n_crlf     = cur_crlf;
        n_flags    = cur_flags;
        n_body     = cur_body;
        first_crlf = 1'b0;
        end_header = 1'b0;
        if (move) begin
            if (cur_phase == PH_BODY) begin
                if (cur_body != '1) begin
                    n_body = cur_body + 1'b1;
                end
            end else begin
                if (r_in_byte == CH_CR) begin
                    n_crlf = (cur_crlf == CRLF_CRLF) ? CRLF_CRLFCR : CRLF_CR;
                end else if (r_in_byte == CH_LF) begin
                    n_crlf = CRLF_NONE;
                    if (cur_crlf == CRLF_CR) begin
                        n_crlf     = CRLF_CRLF;
                        first_crlf = 1'b1;
                    end else if (cur_crlf == CRLF_CRLFCR) begin
                        end_header = 1'b1;
                    end
                end else begin
                    n_crlf = CRLF_NONE;
                end

                if (cur_phase == PH_HEADER) begin
                    for (int i = 0; i < NPAT; i++) begin
                        if (hit[i]) begin
                            n_flags[PAT_FLAG[i]] = 1'b1;
                        end
                    end
                    if (end_header) begin
                        n_phase = PH_BODY;
                    end
                end else if (first_crlf) begin
                    n_phase = PH_HEADER;
                end
            end
        end
    end

    // completeness decision on the updated state
    always_comb begin
        if (n_phase != PH_BODY) begin
            n_status = ST_NEED_MORE;
        end else if (n_flags[FLAG_LEN]) begin
            if (len_err_next || (len_next == '0)) begin
                n_status = ST_ERROR;
            end else if (n_body == len_next) begin
                n_status = n_flags[FLAG_CLOSE] ? ST_COMPLETE_CLOSE : ST_COMPLETE;
            end else if (n_body > len_next) begin
                n_status = ST_ERROR;
            end else begin
                n_status = ST_NEED_MORE;
            end
        end else if (n_flags[FLAG_CHUNK]) begin
            n_status = ST_ERROR;
        end else if (n_flags[FLAG_CLOSE]) begin
            n_status = ST_NEED_MORE;
        end else begin
            n_status = ST_ERROR;
        end
    end

    // fit the counts to the result field width
    assign len_ext  = {{OUT_W{1'b0}}, len_next};
    assign body_ext = {{OUT_W{1'b0}}, n_body};

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_STATUS;
            r_crlf  <= CRLF_NONE;
            r_flags <= '0;
            r_body  <= '0;
        end else begin
            r_phase <= n_phase;
            r_crlf  <= n_crlf;
            r_flags <= n_flags;
            r_body  <= n_body;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_out_status <= ST_NEED_MORE;
            r_out_header <= 1'b0;
            r_out_flags  <= '0;
            r_out_length <= '0;
            r_out_body   <= '0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_out_status <= n_status;
                r_out_header <= (n_phase == PH_BODY);
                r_out_flags  <= n_flags;
                r_out_length <= len_ext[OUT_W-1:0];
                r_out_body   <= body_ext[OUT_W-1:0];
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_header_seen    = r_out_header;
    assign o_close_seen     = r_out_flags[FLAG_CLOSE];
    assign o_length_seen    = r_out_flags[FLAG_LEN];
    assign o_chunked_seen   = r_out_flags[FLAG_CHUNK];
    assign o_content_length = r_out_length;
    assign o_body_bytes     = r_out_body;

    // checks
    a_complete_needs_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_COMPLETE || o_status == ST_COMPLETE_CLOSE)
            |-> o_header_seen && o_length_seen)
        else $error("complete status without header and length");

    a_no_header_need_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_header_seen |-> o_status == ST_NEED_MORE)
        else $error("status other than need_more before header end");

    a_body_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_body_bytes != '0) |-> o_header_seen)
        else $error("body bytes counted before header end");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while result stage can move");

endmodule

// ===== sim/tb_top.sv =====
// ============================================================================
// tb_top
// Byte-level check of the HTTP response completeness block. Short directed
// byte runs, then randomized responses (status line, header lines with close,
// length and chunked fields in random case, decoys and noise, bodies around
// the announced length) are sent with random gaps and result stalls. Every
// result is compared field by field with a per-byte framing predictor.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hrcc_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1050;

    localparam longint unsigned LEN_MAX = 64'h0000_0000_FFFF_FFFF;

    localparam byte unsigned CH_TAB = 8'h09;
    localparam byte unsigned CH_LF  = 8'h0A;
    localparam byte unsigned CH_VT  = 8'h0B;
    localparam byte unsigned CH_FF  = 8'h0C;
    localparam byte unsigned CH_CR  = 8'h0D;
    localparam byte unsigned CH_SP  = 8'h20;

    typedef enum int {PH_STATUS, PH_HEADER, PH_BODY} t_frame_phase;
    typedef enum int {NUM_IDLE, NUM_WS, NUM_SIGN, NUM_DIGITS, NUM_DONE} t_num_phase;

    typedef struct {
        byte unsigned data;
        bit           fresh;
    } t_rx_item;

    typedef struct {
        t_status            status;
        bit                 hdr;
        bit                 cls;
        bit                 len;
        bit                 chk;
        logic [OUT_W-1:0]   clen;
        logic [OUT_W-1:0]   nbody;
    } t_framing;

    // header patterns in lower case; input bytes are folded before matching
    string hdr_pat [NPAT] = '{
        "connection: close",
        "connection:close",
        "content-length:",
        "transfer-encoding: chunked",
        "transfer-encoding:chunked"
    };
    string        big_num [3] = '{"4294967295", "4294967296", "18446744073709551617"};
    byte unsigned ws_set [8]  = '{CH_SP, CH_SP, CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

    // dut ports
    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               o_stall;
    logic [7:0]         i_rx_byte      = 8'h00;
    logic               i_new_response = 1'b0;
    logic               o_valid;
    logic               i_stall        = 1'b0;
    t_status            o_status;
    logic               o_header_seen;
    logic               o_close_seen;
    logic               o_length_seen;
    logic               o_chunked_seen;
    logic [OUT_W-1:0]   o_content_length;
    logic [OUT_W-1:0]   o_body_bytes;

    // framing predictor state
    t_frame_phase       fr_phase;
    int                 crlf_run;
    int                 pat_prog [NPAT];
    logic [FLAG_W-1:0]  hdr_flags;
    t_num_phase         num_phase;
    longint unsigned    len_value;
    longint unsigned    body_count;
    bit                 len_negative;

    // stimulus and checking
    t_rx_item           rx_pending [$];
    t_framing           verdicts_due [$];
    bit                 fresh_next   = 1'b0;
    int                 items_total  = 0;
    int                 bytes_taken  = 0;
    int                 fail_count   = 0;
    bit                 byte_taken   = 1'b0;
    bit                 result_taken = 1'b0;
    int                 send_wait    = 0;
    int                 recv_wait    = 0;
    bit                 calm_send    = 1'b0;
    bit                 calm_recv    = 1'b0;
    int                 quiet_cycles = 0;

    http_response_completeness_check dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .i_new_response   (i_new_response),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_header_seen    (o_header_seen),
        .o_close_seen     (o_close_seen),
        .o_length_seen    (o_length_seen),
        .o_chunked_seen   (o_chunked_seen),
        .o_content_length (o_content_length),
        .o_body_bytes     (o_body_bytes)
    );

    always #5 i_clk = ~i_clk;

    function automatic void clear_parser();
        fr_phase = PH_STATUS;
        crlf_run = 0;
        foreach (pat_prog[i]) pat_prog[i] = 0;
        hdr_flags    = '0;
        num_phase    = NUM_IDLE;
        len_value    = 0;
        body_count   = 0;
        len_negative = 1'b0;
    endfunction

    // advance the framing state by one byte and return the result it causes
    function automatic t_framing frame_byte(byte unsigned c, bit fresh);
        t_framing         r;
        bit               end_hdr;
        bit               first_crlf;
        bit               take;
        bit               ok;
        byte unsigned     lc;
        byte unsigned     ch;
        int               n;
        int               pos;
        int               hit;
        longint unsigned  d;
        if (fresh) clear_parser();
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        if (fr_phase == PH_BODY) begin
            // body bytes are only counted
            if (body_count < LEN_MAX) body_count++;
        end else begin
            // cr lf cr lf tracking
            end_hdr    = 1'b0;
            first_crlf = 1'b0;
            if (c == CH_CR) begin
                crlf_run = (crlf_run == 2) ? 3 : 1;
            end else if (c == CH_LF) begin
                first_crlf = (crlf_run == 1);
                end_hdr    = (crlf_run == 3);
                crlf_run   = first_crlf ? 2 : 0;
            end else begin
                crlf_run = 0;
            end

            if (fr_phase == PH_HEADER) begin
                // length value, base-10 strtol style: white space, sign, digits
                take = 1'b0;
                if (num_phase == NUM_WS) begin
                    if (c == "+" || c == "-") begin
                        len_negative = (c == "-");
                        num_phase    = NUM_SIGN;
                    end else if (!(c == CH_SP || (c >= CH_TAB && c <= CH_CR))) begin
                        num_phase = NUM_SIGN;
                        take      = 1'b1;
                    end
                end else if (num_phase == NUM_SIGN || num_phase == NUM_DIGITS) begin
                    take = 1'b1;
                end
                if (take) begin
                    if (c >= "0" && c <= "9") begin
                        d = c - "0";
                        if (len_value > (LEN_MAX - d) / 10) len_value = LEN_MAX;
                        else len_value = len_value * 10 + d;
                        num_phase = NUM_DIGITS;
                    end else begin
                        num_phase = NUM_DONE;
                    end
                end

                // substring matchers: longest pattern prefix ending at this byte
                for (int i = 0; i < NPAT; i++) begin
                    n = hdr_pat[i].len();
                    if (pat_prog[i] < n) begin
                        hit = 0;
                        for (int k = pat_prog[i] + 1; k >= 1 && hit == 0; k--) begin
                            ok = 1'b1;
                            for (int j = 0; j < k; j++) begin
                                pos = pat_prog[i] + 1 - k + j;
                                ch  = (pos < pat_prog[i]) ? hdr_pat[i].getc(pos) : lc;
                                if (ch != hdr_pat[i].getc(j)) ok = 1'b0;
                            end
                            if (ok) hit = k;
                        end
                        pat_prog[i] = hit;
                    end
                    if (pat_prog[i] == n && !hdr_flags[PAT_FLAG[i]]) begin
                        hdr_flags[PAT_FLAG[i]] = 1'b1;
                        if (PAT_FLAG[i] == FLAG_LEN) num_phase = NUM_WS;
                    end
                end
                if (end_hdr) fr_phase = PH_BODY;
            end else if (first_crlf) begin
                fr_phase = PH_HEADER;
            end
        end

        // completeness decision
        if (fr_phase != PH_BODY) begin
            r.status = ST_NEED_MORE;
        end else if (hdr_flags[FLAG_LEN]) begin
            if (len_negative || len_value == 0) r.status = ST_ERROR;
            else if (body_count == len_value) begin
                if (hdr_flags[FLAG_CLOSE]) r.status = ST_COMPLETE_CLOSE;
                else r.status = ST_COMPLETE;
            end else if (body_count > len_value) r.status = ST_ERROR;
            else r.status = ST_NEED_MORE;
        end else if (hdr_flags[FLAG_CHUNK]) begin
            r.status = ST_ERROR;
        end else if (hdr_flags[FLAG_CLOSE]) begin
            r.status = ST_NEED_MORE;
        end else begin
            r.status = ST_ERROR;
        end
        r.hdr   = (fr_phase == PH_BODY);
        r.cls   = hdr_flags[FLAG_CLOSE];
        r.len   = hdr_flags[FLAG_LEN];
        r.chk   = hdr_flags[FLAG_CHUNK];
        r.clen  = len_value[OUT_W-1:0];
        r.nbody = body_count[OUT_W-1:0];
        return r;
    endfunction

    function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    function automatic int draw_wait(inout bit calm);
        // flip now and then between gap-free stretches and random gaps
        if ($urandom_range(0, 39) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic void push_byte(byte unsigned c);
        rx_pending.push_back('{data: c, fresh: fresh_next});
        fresh_next = 1'b0;
    endfunction

    function automatic void push_crlf();
        push_byte(CH_CR);
        push_byte(CH_LF);
    endfunction

    // letters go out in random case
    function automatic void push_text(string s);
        byte unsigned ch;
        for (int i = 0; i < s.len(); i++) begin
            ch = s.getc(i);
            if (((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z")) && $urandom_range(0, 1))
                ch = ch ^ 8'h20;
            push_byte(ch);
        end
    endfunction

    function automatic void push_printable(int n);
        repeat (n) push_byte(8'($urandom_range(8'h20, 8'h7E)));
    endfunction

    // stimulus, reset and end of run
    initial begin : stimulus
        int     directed_n;
        int     start;
        int     target;
        int     body_n;
        int     v;
        int     k;
        bit     first_len;
        bit     neg;
        string  txt;
        clear_parser();

        // status line of extreme bytes, empty header, body with a late blank line
        fresh_next = 1'b1;
        push_byte(8'hFF);
        push_byte(8'h00);
        push_crlf();
        push_crlf();
        push_byte(8'h00);
        push_byte(8'hFF);
        push_crlf();
        push_crlf();
        // cr cr lf still ends the status line, lone lf does not count
        fresh_next = 1'b1;
        push_byte(CH_CR);
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_byte(CH_LF);
        // fresh response in the middle of a blank line
        fresh_next = 1'b1;
        push_crlf();
        push_byte(CH_CR);
        fresh_next = 1'b1;
        push_byte(CH_CR);
        push_byte(CH_LF);
        directed_n = rx_pending.size();

        // random responses, mostly well formed
        while (rx_pending.size() - directed_n < RANDOM_ITEMS) begin
            start      = rx_pending.size();
            fresh_next = 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                // raw noise, fresh or continuing the previous response
                fresh_next = 1'($urandom_range(0, 1));
                repeat ($urandom_range(1, 20)) push_byte(8'($urandom_range(0, 255)));
            end else begin
                // status line; patterns here must not count
                case ($urandom_range(0, 4))
                    0: push_text("HTTP/1.1 200 OK");
                    1: push_text(hdr_pat[$urandom_range(0, NPAT - 1)]);
                    default: push_printable($urandom_range(0, 4));
                endcase
                push_crlf();

                target    = -1;
                first_len = 1'b1;
                repeat ($urandom_range(0, 3)) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: begin
                            // content length field
                            push_text(hdr_pat[PAT_LENGTH]);
                            repeat ($urandom_range(0, 2)) push_byte(ws_set[$urandom_range(0, 7)]);
                            neg = 1'b0;
                            k   = $urandom_range(0, 9);
                            if (k == 0) begin
                                push_byte("-");
                                neg = 1'b1;
                            end else if (k == 1) begin
                                push_byte("+");
                            end
                            v = -1;
                            k = $urandom_range(0, 15);
                            if (k == 0) txt = "";
                            else if (k == 1) txt = big_num[$urandom_range(0, 2)];
                            else begin
                                v   = $urandom_range(0, 20);
                                txt = $sformatf("%0d", v);
                            end
                            push_text(txt);
                            if (first_len && !neg && v >= 0) target = v;
                            first_len = 1'b0;
                            if ($urandom_range(0, 3) == 0) push_byte(8'($urandom_range(0, 255)));
                            push_crlf();
                        end
                        3: begin
                            push_text(hdr_pat[$urandom_range(PAT_CLOSE_A, PAT_CLOSE_B)]);
                            push_crlf();
                        end
                        4: begin
                            push_text(hdr_pat[$urandom_range(PAT_CHUNK_A, PAT_CHUNK_B)]);
                            push_crlf();
                        end
                        5, 6: begin
                            push_printable($urandom_range(0, 8));
                            push_crlf();
                        end
                        7: begin
                            // partial pattern, sometimes run straight into a full one
                            k = $urandom_range(0, NPAT - 1);
                            push_text(hdr_pat[k].substr(0, $urandom_range(0, hdr_pat[k].len() - 2)));
                            if ($urandom_range(0, 1)) push_text(hdr_pat[$urandom_range(0, NPAT - 1)]);
                            push_crlf();
                        end
                        8: begin
                            repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
                            push_crlf();
                        end
                        default: begin
                            push_printable($urandom_range(1, 3));
                            push_text(hdr_pat[$urandom_range(0, NPAT - 1)]);
                            push_crlf();
                        end
                    endcase
                end
                push_crlf();

                // body: mostly the announced length, sometimes too long
                k = $urandom_range(0, 9);
                if (target >= 0 && k < 7) body_n = target;
                else if (target >= 0 && k < 9) body_n = target + $urandom_range(1, 3);
                else body_n = $urandom_range(0, 6);
                repeat (body_n) push_byte(8'($urandom_range(0, 255)));

                // sometimes cut short; the next response starts fresh
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(0, rx_pending.size() - start - 1))
                        void'(rx_pending.pop_back());
            end
        end
        items_total = rx_pending.size();

        // reset
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drain
        while (!(bytes_taken == items_total && verdicts_due.size() == 0)) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // input driver: new item only after the current one was taken
    always @(negedge i_clk) begin : rx_driver
        t_rx_item it;
        if (i_rst_n && (!i_valid || byte_taken)) begin
            if (send_wait > 0) begin
                i_valid   <= 1'b0;
                send_wait <= send_wait - 1;
            end else if (rx_pending.size() > 0) begin
                it = rx_pending.pop_front();
                i_valid        <= 1'b1;
                i_rx_byte      <= it.data;
                i_new_response <= it.fresh;
                send_wait      <= draw_wait(calm_send);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result side stall, drawn after every taken result
    always @(negedge i_clk) begin : result_stall
        int w;
        if (result_taken) begin
            w = draw_wait(calm_recv);
            i_stall   <= (w > 0);
            recv_wait <= (w > 0) ? w - 1 : 0;
        end else if (recv_wait > 0) begin
            i_stall   <= 1'b1;
            recv_wait <= recv_wait - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // monitor: check taken results, predict for taken bytes
    always @(posedge i_clk) begin : monitor
        t_framing want;
        byte_taken   <= i_rst_n && i_valid && !o_stall;
        result_taken <= i_rst_n && o_valid && !i_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            if (verdicts_due.size() == 0) begin
                fail_count++;
                $display("%0t: result with no byte pending, expected none, actual status %0d",
                         $time, o_status);
            end else begin
                want = verdicts_due.pop_front();
                check_field("status", want.status, o_status);
                check_field("header_seen", want.hdr, o_header_seen);
                check_field("close_seen", want.cls, o_close_seen);
                check_field("length_seen", want.len, o_length_seen);
                check_field("chunked_seen", want.chk, o_chunked_seen);
                check_field("content_length", want.clen, o_content_length);
                check_field("body_bytes", want.nbody, o_body_bytes);
            end
        end
        if (i_rst_n && i_valid && !o_stall) begin
            verdicts_due.push_back(frame_byte(i_rx_byte, i_new_response));
            bytes_taken <= bytes_taken + 1;
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin : watchdog
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
